>>> rtl/bpv_pkg.sv
// ----------------------------------------------------------------------------
// bpv_pkg
// Types, byte kinds, verdict codes and lookup functions for the validator.
// ----------------------------------------------------------------------------
`default_nettype none
package bpv_pkg;

  localparam logic [2:0] KIND_HEADER  = 3'd0;
  localparam logic [2:0] KIND_OPCODE  = 3'd1;
  localparam logic [2:0] KIND_STR1    = 3'd2;
  localparam logic [2:0] KIND_STR2    = 3'd3;
  localparam logic [2:0] KIND_NUM     = 3'd4;
  localparam logic [2:0] KIND_DATA    = 3'd5;
  localparam logic [2:0] KIND_SURPLUS = 3'd6;
  localparam logic [2:0] KIND_NONE    = 3'd0;

  localparam logic [2:0] VERDICT_OK       = 3'd0;
  localparam logic [2:0] VERDICT_BAD_SIG  = 3'd1;
  localparam logic [2:0] VERDICT_SIZE     = 3'd2;
  localparam logic [2:0] VERDICT_CRC      = 3'd3;
  localparam logic [2:0] VERDICT_MISFIT   = 3'd4;

  localparam int unsigned HdrLen     = 18;
  localparam int unsigned SigLen     = 14;
  localparam logic [10:0] PayloadMax = 11'd2047;
  localparam logic [3:0]  RowUnknown = 4'd9;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [7:0]  byte_value;
    logic [2:0]  byte_kind;
    logic        packet_end;
    logic [2:0]  verdict;
    logic [15:0] opcode;
    logic [63:0] file_size;
    logic [63:0] file_offset;
    logic [10:0] payload_length;
    logic [15:0] computed_crc;
  } out_t;

  function automatic logic [7:0] sig_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h42;
      4'd1:    b = 8'h43;
      4'd2:    b = 8'h4C;
      4'd3:    b = 8'h4F;
      4'd4:    b = 8'h4E;
      4'd5:    b = 8'h45;
      4'd6:    b = 8'h20;
      4'd7:    b = 8'h50;
      4'd8:    b = 8'h4B;
      4'd9:    b = 8'h47;
      4'd10:   b = 8'h20;
      4'd11:   b = 8'h76;
      4'd12:   b = 8'h31;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Field list for one opcode row; row 9 is any unknown opcode.
  function automatic logic [2:0] field_at(input logic [3:0] row, input logic [2:0] step);
    logic [2:0] k;
    k = KIND_NONE;
    if (step == 3'd0) begin
      if (row != RowUnknown) k = KIND_STR1;
    end else if (step == 3'd1) begin
      case (row)
        4'd1, 4'd2, 4'd3, 4'd6, 4'd8: k = KIND_STR2;
        4'd4, 4'd5:                   k = KIND_NUM;
        default:                      k = KIND_NONE;
      endcase
    end else if (step == 3'd2) begin
      case (row)
        4'd1, 4'd2, 4'd3, 4'd6, 4'd8: k = KIND_NUM;
        4'd4, 4'd5:                   k = KIND_DATA;
        default:                      k = KIND_NONE;
      endcase
    end else if (step == 3'd3) begin
      if (row == 4'd6) k = KIND_DATA;
    end
    return k;
  endfunction

  // Reflected CRC-16, polynomial 0x8005.
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> rtl/bpv_front.sv
// ----------------------------------------------------------------------------
// bpv_front
// Parse state: tag each accepted byte and build the result, verdict on last.
// ----------------------------------------------------------------------------
`default_nettype none
module bpv_front #(
  parameter int unsigned MAX_PACKET = 1024
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           accept_i,
  input  wire bpv_pkg::in_t   in_data_i,
  output bpv_pkg::out_t       result_o
);
  localparam int unsigned PW = $clog2(MAX_PACKET + 1);
  localparam int unsigned CW = ((PW > 17) ? PW : 17) + 1;

  logic [PW-1:0] pos_q, pos_d;
  logic          sig_q, sig_d;
  logic [15:0]   rcrc_q, rcrc_d, blen_q, blen_d, crc_q, crc_d, opc_q, opc_d;
  logic [2:0]    step_q, step_d;
  logic [3:0]    nbc_q, nbc_d;
  logic [63:0]   acc_q, acc_d;
  logic [10:0]   pay_q, pay_d;
  logic          misfit_q, misfit_d, over_q, over_d;

  logic [7:0]  b;
  logic [2:0]  kind, fk, end_k;
  logic [3:0]  row, end_row;
  logic        num_done, fits;
  logic [2:0]  verdict;

  always_comb begin
    b = in_data_i.data_byte;
    pos_d = pos_q; sig_d = sig_q; rcrc_d = rcrc_q; blen_d = blen_q;
    crc_d = crc_q; opc_d = opc_q; step_d = step_q; nbc_d = nbc_q;
    acc_d = acc_q; pay_d = pay_q; misfit_d = misfit_q; over_d = over_q;
    kind = bpv_pkg::KIND_SURPLUS;
    row = (opc_q <= 16'd8) ? opc_q[3:0] : bpv_pkg::RowUnknown;
    fk = bpv_pkg::field_at(row, step_q);

    if (over_q || (pos_q >= PW'(MAX_PACKET))) begin
      over_d = 1'b1;
    end else begin
      pos_d = pos_q + PW'(1);
      if (pos_q < PW'(bpv_pkg::SigLen)) begin
        if (b != bpv_pkg::sig_byte(pos_q[3:0])) sig_d = 1'b0;
        kind = bpv_pkg::KIND_HEADER;
      end else if (pos_q < PW'(16)) begin
        rcrc_d = {rcrc_q[7:0], b};
        kind = bpv_pkg::KIND_HEADER;
      end else if (pos_q < PW'(bpv_pkg::HdrLen)) begin
        blen_d = {blen_q[7:0], b};
        kind = bpv_pkg::KIND_HEADER;
      end else if (CW'(pos_q) >= CW'(bpv_pkg::HdrLen) + CW'(blen_q)) begin
        kind = bpv_pkg::KIND_SURPLUS;
      end else begin
        crc_d = bpv_pkg::crc_update(crc_q, b);
        if (pos_q < PW'(bpv_pkg::HdrLen + 2)) begin
          opc_d = {opc_q[7:0], b};
          kind = bpv_pkg::KIND_OPCODE;
        end else begin
          kind = fk;
          case (fk)
            bpv_pkg::KIND_NONE: begin
              misfit_d = 1'b1;
              kind = bpv_pkg::KIND_SURPLUS;
            end
            bpv_pkg::KIND_STR1, bpv_pkg::KIND_STR2: begin
              if (b == 8'h00) step_d = step_q + 3'd1;
            end
            bpv_pkg::KIND_NUM: begin
              acc_d = {acc_q[55:0], b};
              if (nbc_q == 4'd7) begin
                nbc_d = 4'd0;
                step_d = step_q + 3'd1;
              end else begin
                nbc_d = nbc_q + 4'd1;
              end
            end
            default: begin
              if (pay_q < bpv_pkg::PayloadMax) pay_d = pay_q + 11'd1;
            end
          endcase
        end
      end
    end

    // End-of-datagram verdict on the updated state.
    end_row = (opc_d <= 16'd8) ? opc_d[3:0] : bpv_pkg::RowUnknown;
    end_k = bpv_pkg::field_at(end_row, step_d);
    num_done = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if ((3'(i) < step_d) && (bpv_pkg::field_at(end_row, 3'(i)) == bpv_pkg::KIND_NUM))
        num_done = 1'b1;
    end
    fits = !misfit_d && (blen_d >= 16'd2) &&
           ((end_k == bpv_pkg::KIND_NONE) || (end_k == bpv_pkg::KIND_DATA));
    if (!sig_d) verdict = bpv_pkg::VERDICT_BAD_SIG;
    else if (over_d || (CW'(pos_d) != CW'(bpv_pkg::HdrLen) + CW'(blen_d)))
      verdict = bpv_pkg::VERDICT_SIZE;
    else if (crc_d != rcrc_d) verdict = bpv_pkg::VERDICT_CRC;
    else if (!fits) verdict = bpv_pkg::VERDICT_MISFIT;
    else verdict = bpv_pkg::VERDICT_OK;

    result_o = '0;
    result_o.byte_value = b;
    result_o.byte_kind  = kind;
    if (in_data_i.last_byte) begin
      result_o.packet_end     = 1'b1;
      result_o.verdict        = verdict;
      result_o.opcode         = opc_d;
      result_o.payload_length = pay_d;
      result_o.computed_crc   = crc_d;
      if (num_done) begin
        if (end_row == 4'd4 || end_row == 4'd5 || end_row == 4'd6)
          result_o.file_offset = acc_d;
        else
          result_o.file_size = acc_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; sig_q <= 1'b1; rcrc_q <= '0; blen_q <= '0; crc_q <= '0;
      opc_q <= '0; step_q <= '0; nbc_q <= '0; acc_q <= '0; pay_q <= '0;
      misfit_q <= 1'b0; over_q <= 1'b0;
    end else if (accept_i) begin
      if (in_data_i.last_byte) begin
        // clear for the next datagram
        pos_q <= '0; sig_q <= 1'b1; rcrc_q <= '0; blen_q <= '0; crc_q <= '0;
        opc_q <= '0; step_q <= '0; nbc_q <= '0; acc_q <= '0; pay_q <= '0;
        misfit_q <= 1'b0; over_q <= 1'b0;
      end else begin
        pos_q <= pos_d; sig_q <= sig_d; rcrc_q <= rcrc_d; blen_q <= blen_d;
        crc_q <= crc_d; opc_q <= opc_d; step_q <= step_d; nbc_q <= nbc_d;
        acc_q <= acc_d; pay_q <= pay_d; misfit_q <= misfit_d; over_q <= over_d;
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/bpv_queue.sv
// ----------------------------------------------------------------------------
// bpv_queue
// Two-entry result queue between the parser and the output port.
// ----------------------------------------------------------------------------
`default_nettype none
module bpv_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire bpv_pkg::out_t push_data_i,
  output logic               full_o,
  output logic               valid_o,
  input  wire logic          pop_i,
  output bpv_pkg::out_t      data_o
);
  bpv_pkg::out_t mem_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 2'd1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 2'd1;
    end
  end
endmodule
`default_nettype wire

>>> rtl/broadcast_packet_validator.sv
// Each result is registered in the queue when its byte is accepted.
// Throughput: one byte per cycle unless in_stall_o is high; the parser updates
// all state in one step and a two-entry queue decouples it from output stalls.
// Reset: asynchronous active-low; clears the parse state and empties the queue.
// ----------------------------------------------------------------------------
// broadcast_packet_validator
// Byte-wise datagram checker: signature, size, CRC-16 and field walk.
// ----------------------------------------------------------------------------
`default_nettype none
module broadcast_packet_validator #(
  parameter int unsigned MAX_PACKET = 1024
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire bpv_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output bpv_pkg::out_t      out_data_o
);
  logic          accept, full;
  bpv_pkg::out_t result;

  // Hold input while the queue is full; accept otherwise.
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  bpv_front #(.MAX_PACKET(MAX_PACKET)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .result_o  (result)
  );

  // Advance results to the port; drop from the queue once taken.
  bpv_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (result),
    .full_o      (full),
    .valid_o     (out_valid_o),
    .pop_i       (out_valid_o && !out_stall_i),
    .data_o      (out_data_o)
  );

`ifndef SYNTHESIS
  a_push_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o) else $error("accepted request missing from queue");
  a_midpacket_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.packet_end) |->
    (out_data_o.verdict == bpv_pkg::VERDICT_OK && out_data_o.file_size == 64'd0))
    else $error("verdict fields set before packet end");
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.byte_kind <= bpv_pkg::KIND_SURPLUS))
    else $error("illegal byte kind");
`endif
endmodule
`default_nettype wire
